// ===== rtl/core/ept_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ept_pkg;

  // CORDIC arc-tangent table in 32-bit phase units (2^32 is one turn).
  localparam int MaxStages = 24;

  // Q2.30 CORDIC gain pre-compensation.
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Width of the CORDIC x, y and z datapaths.
  localparam int TrigW = 34;

  function automatic logic signed [33:0] atan_entry(input int idx);
    logic signed [33:0] r;
    case (idx)
      0:  r = 34'sh20000000;
      1:  r = 34'sh12E4051E;
      2:  r = 34'sh09FB385B;
      3:  r = 34'sh051111D4;
      4:  r = 34'sh028B0D43;
      5:  r = 34'sh0145D7E1;
      6:  r = 34'sh00A2F61E;
      7:  r = 34'sh00517C55;
      8:  r = 34'sh0028BE53;
      9:  r = 34'sh00145F2F;
      10: r = 34'sh000A2F98;
      11: r = 34'sh000517CC;
      12: r = 34'sh00028BE6;
      13: r = 34'sh000145F3;
      14: r = 34'sh0000A2FA;
      15: r = 34'sh0000517D;
      16: r = 34'sh000028BE;
      17: r = 34'sh0000145F;
      18: r = 34'sh00000A30;
      19: r = 34'sh00000518;
      20: r = 34'sh0000028C;
      21: r = 34'sh00000146;
      22: r = 34'sh000000A3;
      23: r = 34'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Pose transaction.
  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } pose_t;

  // Transform transaction.
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } xform_t;

endpackage
`default_nettype wire

// ===== rtl/core/ept_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ept_pose_if import ept_pkg::*; ();
  logic  valid;
  logic  ready;
  pose_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ept_xform_if import ept_pkg::*; ();
  logic   valid;
  logic   ready;
  xform_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ept_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ept_cordic import ept_pkg::*; #(
  parameter int ANGLE_BITS  = 16,
  parameter int TRIG_STAGES = 16
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [ANGLE_BITS-1:0]   angle,
  output logic signed [TrigW-1:0]      sin_q30,
  output logic signed [TrigW-1:0]      cos_q30
);

  localparam int NSt = (TRIG_STAGES > MaxStages) ? MaxStages : TRIG_STAGES;

  logic signed [TrigW-1:0] x [NSt+1];
  logic signed [TrigW-1:0] y [NSt+1];
  logic signed [TrigW-1:0] z [NSt+1];
  logic                    flip [NSt+1];

  // Quadrant folding into [-pi/2, pi/2).
  logic [31:0] ph;
  logic [31:0] ph_f;
  logic        fl;
  always_comb begin
    ph   = {angle, {(32-ANGLE_BITS){1'b0}}};
    fl   = ph[31] ^ ph[30];
    ph_f = fl ? (ph + 32'h80000000) : ph;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CordicGain;
      y[0]    <= '0;
      z[0]    <= TrigW'($signed(ph_f));
      flip[0] <= fl;
    end
  end

  // One registered micro-rotation per stage.
  for (genvar i = 0; i < NSt; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][TrigW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_entry(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_entry(i);
        end
        flip[i+1] <= flip[i];
      end
    end
  end

  // Undo the fold.
  always_ff @(posedge clk) begin
    if (en) begin
      sin_q30 <= flip[NSt] ? -y[NSt] : y[NSt];
      cos_q30 <= flip[NSt] ? -x[NSt] : x[NSt];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/euler_pose_to_transform_matrix_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each pose goes through the CORDIC input, rotation and output registers, then stages A to E.
// Throughput: one pose per cycle unless the output stalls; all stages are fully pipelined.
// The whole pipeline advances together; a stalled output holds every stage in place.
// Reset clears the valid bits only; payload registers are not reset.
module euler_pose_to_transform_matrix_unit import ept_pkg::*; #(
  parameter int ANGLE_BITS     = 16,
  parameter int COEF_FRAC_BITS = 14,
  parameter int TRIG_STAGES    = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  ept_pose_if.sink    in_pose,
  ept_xform_if.source out_xform
);

  localparam int NSt  = (TRIG_STAGES > MaxStages) ? MaxStages : TRIG_STAGES;
  localparam int Lat  = NSt + 7;
  localparam int Sh   = 60 - COEF_FRAC_BITS;
  localparam int PW   = 68;

  logic en;
  logic [Lat-1:0] vld;

  // The pipeline moves whenever the output is free or being taken.
  assign en            = !out_xform.valid || out_xform.ready;
  assign in_pose.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_pose.valid};
    end
  end

  logic signed [TrigW-1:0] sy, cy, sp, cp, sr, cr;

  ept_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_yaw (
    .clk(clk), .en(en), .angle(in_pose.data.yaw_angle[ANGLE_BITS-1:0]),
    .sin_q30(sy), .cos_q30(cy));
  ept_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_pitch (
    .clk(clk), .en(en), .angle(in_pose.data.pitch_angle[ANGLE_BITS-1:0]),
    .sin_q30(sp), .cos_q30(cp));
  ept_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_roll (
    .clk(clk), .en(en), .angle(in_pose.data.roll_angle[ANGLE_BITS-1:0]),
    .sin_q30(sr), .cos_q30(cr));

  // Translation delay line matching the full pipeline depth.
  logic signed [31:0] tx [Lat];
  logic signed [31:0] ty [Lat];
  logic signed [31:0] tz [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      tx[0] <= in_pose.data.offset_x;
      ty[0] <= in_pose.data.offset_y;
      tz[0] <= in_pose.data.offset_z;
      for (int k = 1; k < Lat; k++) begin
        tx[k] <= tx[k-1];
        ty[k] <= ty[k-1];
        tz[k] <= tz[k-1];
      end
    end
  end

  // Stage A: first products, trig values carried along.
  logic signed [PW-1:0] a_cysp, a_sysp, a_cycp, a_cpsy, a_cpsr, a_cpcr;
  logic signed [PW-1:0] a_crsy, a_sysr, a_cycr, a_cysr;
  logic signed [TrigW-1:0] a_sr, a_cr, a_sp;
  always_ff @(posedge clk) begin
    if (en) begin
      a_cysp <= PW'(cy) * PW'(sp);
      a_sysp <= PW'(sy) * PW'(sp);
      a_cycp <= PW'(cy) * PW'(cp);
      a_cpsy <= PW'(cp) * PW'(sy);
      a_cpsr <= PW'(cp) * PW'(sr);
      a_cpcr <= PW'(cp) * PW'(cr);
      a_crsy <= PW'(cr) * PW'(sy);
      a_sysr <= PW'(sy) * PW'(sr);
      a_cycr <= PW'(cy) * PW'(cr);
      a_cysr <= PW'(cy) * PW'(sr);
      a_sr   <= sr;
      a_cr   <= cr;
      a_sp   <= sp;
    end
  end

  // Stage B: round the pitch products back to Q30.
  logic signed [PW-1:0] b_cycp, b_cpsy, b_cpsr, b_cpcr, b_crsy, b_sysr, b_cycr, b_cysr, b_msp;
  logic signed [TrigW-1:0] b_cysp, b_sysp, b_sr, b_cr;
  always_ff @(posedge clk) begin
    if (en) begin
      b_cysp <= TrigW'((a_cysp + (PW'(1) <<< 29)) >>> 30);
      b_sysp <= TrigW'((a_sysp + (PW'(1) <<< 29)) >>> 30);
      b_cycp <= a_cycp;
      b_cpsy <= a_cpsy;
      b_cpsr <= a_cpsr;
      b_cpcr <= a_cpcr;
      b_crsy <= a_crsy;
      b_sysr <= a_sysr;
      b_cycr <= a_cycr;
      b_cysr <= a_cysr;
      b_msp  <= -(PW'(a_sp) <<< 30);
      b_sr   <= a_sr;
      b_cr   <= a_cr;
    end
  end

  // Stage C: triple products.
  logic signed [PW-1:0] c_p1, c_p2, c_p4, c_p5;
  logic signed [PW-1:0] c_cycp, c_cpsy, c_cpsr, c_cpcr, c_crsy, c_sysr, c_cycr, c_cysr, c_msp;
  always_ff @(posedge clk) begin
    if (en) begin
      c_p1   <= PW'(b_cysp) * PW'(b_sr);
      c_p2   <= PW'(b_cysp) * PW'(b_cr);
      c_p4   <= PW'(b_sysp) * PW'(b_sr);
      c_p5   <= PW'(b_sysp) * PW'(b_cr);
      c_cycp <= b_cycp;
      c_cpsy <= b_cpsy;
      c_cpsr <= b_cpsr;
      c_cpcr <= b_cpcr;
      c_crsy <= b_crsy;
      c_sysr <= b_sysr;
      c_cycr <= b_cycr;
      c_cysr <= b_cysr;
      c_msp  <= b_msp;
    end
  end

  // Stage D: sums in Q60.
  logic signed [PW-1:0] d_q [9];
  always_ff @(posedge clk) begin
    if (en) begin
      d_q[0] <= c_cycp;
      d_q[1] <= c_p1 - c_crsy;
      d_q[2] <= c_p2 + c_sysr;
      d_q[3] <= c_cpsy;
      d_q[4] <= c_cycr + c_p4;
      d_q[5] <= c_p5 - c_cysr;
      d_q[6] <= c_msp;
      d_q[7] <= c_cpsr;
      d_q[8] <= c_cpcr;
    end
  end

  // Stage E: round to the coefficient format and saturate to plus or minus one.
  logic signed [PW-1:0] lim;
  logic signed [15:0]   e_m [9];
  assign lim = PW'(1) <<< COEF_FRAC_BITS;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        automatic logic signed [PW-1:0] v = (d_q[k] + (PW'(1) <<< (Sh-1))) >>> Sh;
        if (v > lim) e_m[k] <= 16'(lim);
        else if (v < -lim) e_m[k] <= 16'(-lim);
        else e_m[k] <= 16'(v);
      end
    end
  end

  assign out_xform.valid      = vld[Lat-1];
  assign out_xform.data.m00   = e_m[0];
  assign out_xform.data.m01   = e_m[1];
  assign out_xform.data.m02   = e_m[2];
  assign out_xform.data.m10   = e_m[3];
  assign out_xform.data.m11   = e_m[4];
  assign out_xform.data.m12   = e_m[5];
  assign out_xform.data.m20   = e_m[6];
  assign out_xform.data.m21   = e_m[7];
  assign out_xform.data.m22   = e_m[8];
  assign out_xform.data.out_x = tx[Lat-1];
  assign out_xform.data.out_y = ty[Lat-1];
  assign out_xform.data.out_z = tz[Lat-1];

  // A stalled result must hold its valid bit.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_xform.valid && !out_xform.ready |=> out_xform.valid)
    else $error("result dropped while stalled");

  // The input side is ready exactly when the pipeline advances.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_pose.ready == (!out_xform.valid || out_xform.ready))
    else $error("ready inconsistent with pipeline advance");

  // Entry m20 never exceeds unity in magnitude.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_xform.valid |-> (out_xform.data.m20 <= 16'(lim)) && (out_xform.data.m20 >= 16'(-lim)))
    else $error("entry out of range");

endmodule
`default_nettype wire

// ===== test/euler_pose_to_transform_matrix_unit_tb.sv =====
`timescale 1ns / 1ps

// Scoreboard: predicts the transform for each accepted pose and checks results in order.
class xform_scoreboard;
  ept_pkg::xform_t pending[$];
  int errors = 0;

  // Sine and cosine of a binary angle, Q2.30, by a rotation-mode CORDIC.
  static function void trig_of(input logic [15:0] ang, output longint s_q, output longint c_q);
    logic [31:0] ph;
    logic [1:0] quad;
    bit flip;
    longint z, x, y, xs, ys;
    ph = {ang, 16'h0000};
    quad = ph[31:30];
    flip = (quad == 2'd1) || (quad == 2'd2);
    if (flip) ph = ph + 32'h8000_0000;
    z = longint'(signed'(ph));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ept_pkg::atan_entry(i));
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ept_pkg::atan_entry(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s_q = y;
    c_q = x;
  endfunction

  static function longint round_q30(input longint v);
    return (v + (longint'(1) <<< 29)) >>> 30;
  endfunction

  // Round a Q60 value to Q1.14 and saturate to plus or minus one.
  static function logic signed [15:0] coef_of(input longint v);
    longint r;
    r = (v + (longint'(1) <<< 45)) >>> 46;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function void note_pose(input ept_pkg::pose_t p);
    ept_pkg::xform_t t;
    longint sy, cy, sp, cp, sr, cr, cysp, sysp;
    trig_of(p.yaw_angle, sy, cy);
    trig_of(p.pitch_angle, sp, cp);
    trig_of(p.roll_angle, sr, cr);
    cysp = round_q30(cy * sp);
    sysp = round_q30(sy * sp);
    t.m00 = coef_of(cy * cp);
    t.m01 = coef_of(cysp * sr - cr * sy);
    t.m02 = coef_of(cysp * cr + sy * sr);
    t.m10 = coef_of(cp * sy);
    t.m11 = coef_of(cy * cr + sysp * sr);
    t.m12 = coef_of(sysp * cr - cy * sr);
    t.m20 = coef_of(-sp * (longint'(1) <<< 30));
    t.m21 = coef_of(cp * sr);
    t.m22 = coef_of(cp * cr);
    t.out_x = p.offset_x;
    t.out_y = p.offset_y;
    t.out_z = p.offset_z;
    pending.push_back(t);
  endfunction

  function void check_xform(input ept_pkg::xform_t got);
    ept_pkg::xform_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected transform %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.m00 !== want.m00) report("m00", want.m00, got.m00);
    if (got.m01 !== want.m01) report("m01", want.m01, got.m01);
    if (got.m02 !== want.m02) report("m02", want.m02, got.m02);
    if (got.m10 !== want.m10) report("m10", want.m10, got.m10);
    if (got.m11 !== want.m11) report("m11", want.m11, got.m11);
    if (got.m12 !== want.m12) report("m12", want.m12, got.m12);
    if (got.m20 !== want.m20) report("m20", want.m20, got.m20);
    if (got.m21 !== want.m21) report("m21", want.m21, got.m21);
    if (got.m22 !== want.m22) report("m22", want.m22, got.m22);
    if (got.out_x !== want.out_x) report("out_x", want.out_x, got.out_x);
    if (got.out_y !== want.out_y) report("out_y", want.out_y, got.out_y);
    if (got.out_z !== want.out_z) report("out_z", want.out_z, got.out_z);
  endfunction

  function void report(input string field, input logic signed [31:0] want,
                       input logic signed [31:0] got);
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    errors++;
  endfunction
endclass

module euler_pose_to_transform_matrix_unit_tb;
  import ept_pkg::*;

  localparam int Latency = 23;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  ept_pose_if in_pose ();
  ept_xform_if out_xform ();

  xform_scoreboard board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;
  longint cycles = 0;

  euler_pose_to_transform_matrix_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_pose(in_pose),
    .out_xform(out_xform)
  );

  always #5 clk = ~clk;

  initial begin
    in_pose.valid = 1'b0;
    in_pose.data = '0;
    out_xform.ready = 1'b0;
  end

  // Cycle counter with a hard limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked for.
  always @(posedge clk) begin
    if (rst) begin
      out_xform.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_xform.ready <= 1'b0;
    end else begin
      out_xform.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each result transaction.
  always @(posedge clk) begin
    if (!rst && out_xform.valid && out_xform.ready) board.check_xform(out_xform.data);
  end

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return {2'($urandom_range(3)), 14'h0000} + 16'($urandom_range(2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one pose, idling first at random, and hold it until accepted.
  task automatic send_pose(input logic [15:0] yaw, input logic [15:0] pitch,
                           input logic [15:0] roll, input logic [31:0] ox,
                           input logic [31:0] oy, input logic [31:0] oz);
    pose_t p;
    p = '{yaw, pitch, roll, ox, oy, oz};
    while ($urandom_range(99) < send_idle_pct) begin
      in_pose.valid <= 1'b0;
      @(posedge clk);
    end
    in_pose.valid <= 1'b1;
    in_pose.data <= p;
    @(posedge clk);
    while (!in_pose.ready) @(posedge clk);
    board.note_pose(p);
  endtask

  // The caller follows each batch at once with another send or a drain.
  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_pose(rand_angle(), rand_angle(), rand_angle(), $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    in_pose.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] corner [8];
    corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h3FFF, 16'hBFFF,
               16'h2000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed poses: quadrant edges, extremes of the angles and offsets.
    for (int i = 0; i < 8; i++)
      send_pose(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8],
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_pose(16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
    send_pose(16'hFFFF, 16'h0001, 16'hFFFF, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_pose(16'h4000, 16'h4000, 16'h4000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
    send_pose(16'hC000, 16'hC000, 16'hC000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hEDCB_A987);
    drain();

    // Random phases under different idling patterns.
    send_idle_pct = 0; stall_pct = 0;
    send_random(250);
    send_idle_pct = 57; stall_pct = 0;
    send_random(250);
    send_idle_pct = 0; stall_pct = 57;
    send_random(250);
    send_idle_pct = 7; stall_pct = 7;
    send_random(150);

    // Hold the receiver off long enough to fill the pipeline and stall the input.
    send_idle_pct = 0; stall_pct = 0;
    hold_off = 200;
    send_random(100);
    drain();
    send_random(100);
    drain();
    repeat (Latency + 10) @(posedge clk);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/ept_pkg.sv
rtl/core/ept_if.sv
rtl/core/ept_cordic.sv
rtl/core/euler_pose_to_transform_matrix_unit.sv
test/euler_pose_to_transform_matrix_unit_tb.sv
